// ===== rtl/msb_first_bit_packer_defines.svh =====
// Assertion macros shared by the bit packer RTL.
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// Checked on every rising edge of clk once rst is low.
`define MFBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define MFBP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mfbp_pkg.sv =====
// Shared constants and types of the MSB-first bit packer.
`default_nettype none
package mfbp_pkg;

  localparam int CODE_W    = 64;  // width of the code field
  localparam int CNT_W     = 7;   // width of the bit count field
  localparam int CODE_BITS = 64;  // largest count honored; larger counts are clamped
  localparam int BYTE_W    = 8;
  localparam int FILL_W    = 3;   // bits pending in the partial byte, 0 to 7
  localparam int NEED_W    = 4;   // bits still needed to close a byte, 1 to 8

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // One command handed from the front end to the packing engine.
  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] aligned;  // code bits moved up to bit CODE_W-1
    logic [CNT_W-1:0]  count;    // clamped bit count, never zero for an append
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_t;

endpackage
`default_nettype wire

// ===== rtl/mfbp_if.sv =====
// Valid/ready channel interfaces for code words and packed bytes.
`default_nettype none
interface mfbp_code_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [mfbp_pkg::CODE_W-1:0]  code;
  logic [mfbp_pkg::CNT_W-1:0]   code_len;

  modport source (output valid, func, code, code_len, input ready);
  modport sink   (input valid, func, code, code_len, output ready);
endinterface

interface mfbp_byte_if;
  logic                         valid;
  logic                         ready;
  logic [mfbp_pkg::BYTE_W-1:0]  out_byte;
  logic                         last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/mfbp_front.sv =====
// Front end: accepts code words, clamps the count and left-aligns the code bits.
`default_nettype none
module mfbp_front (
  mfbp_code_if.sink       codes,
  output logic            push_valid,
  input  logic            push_ready,
  output mfbp_pkg::cmd_t  push_cmd
);
  import mfbp_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] shamt;
  logic             is_flush;

  assign is_flush = (codes.func == FUNC_FLUSH);
  assign cnt      = (codes.code_len > CNT_W'(CODE_BITS)) ? CNT_W'(CODE_BITS)
                                                         : codes.code_len;
  assign shamt    = CNT_W'(CODE_W) - cnt;

  // Words that append nothing are taken and dropped here.
  assign codes.ready       = push_ready;
  assign push_valid        = codes.valid && (is_flush || (cnt != '0));
  assign push_cmd.is_flush = is_flush;
  assign push_cmd.aligned  = codes.code << shamt;
  assign push_cmd.count    = cnt;

endmodule
`default_nettype wire

// ===== rtl/mfbp_queue.sv =====
// Two-entry command queue between the front end and the packing engine.
`default_nettype none
module mfbp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  mfbp_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop,
  output mfbp_pkg::cmd_t  pop_cmd
);
  import mfbp_pkg::*;

  `include "msb_first_bit_packer_defines.svh"

  cmd_t        entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `MFBP_ASSERT(a_count_bound, (count != 2'd3), "queue holds more entries than it has")
  `MFBP_ASSERT(a_pop_order, (do_pop |=> (rd_ptr != $past(rd_ptr))), "read pointer did not move")

endmodule
`default_nettype wire

// ===== rtl/mfbp_back.sv =====
// Packing engine: merges code bits into bytes, one byte per cycle unless stalled.
`default_nettype none
module mfbp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  input  mfbp_pkg::cmd_t  cmd,
  mfbp_byte_if.source     bytes
);
  import mfbp_pkg::*;

  `include "msb_first_bit_packer_defines.svh"

  st_t                state;
  st_t                state_next;
  logic [CODE_W-1:0]  sh_code;
  logic [CODE_W-1:0]  sh_code_next;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   rem_next;
  logic [BYTE_W-1:0]  partial;
  logic [BYTE_W-1:0]  partial_next;
  logic [FILL_W-1:0]  filled;
  logic [FILL_W-1:0]  filled_next;
  logic               out_valid;
  logic               out_valid_next;
  logic [BYTE_W-1:0]  out_byte;
  logic [BYTE_W-1:0]  out_byte_next;
  logic               out_last;
  logic               out_last_next;

  logic               adv;
  logic [NEED_W-1:0]  need;
  logic [BYTE_W-1:0]  merged;
  logic               emit_full;
  logic [CNT_W-1:0]   rem_after;

  // The output register may be refilled when it is empty or being taken.
  assign adv       = !out_valid || bytes.ready;
  assign need      = NEED_W'(BYTE_W) - NEED_W'(filled);
  assign merged    = partial | (sh_code[CODE_W-1 -: BYTE_W] >> filled);
  assign emit_full = (rem >= CNT_W'(need));
  assign rem_after = rem - CNT_W'(need);
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid && adv;

  assign bytes.valid    = out_valid;
  assign bytes.out_byte = out_byte;
  assign bytes.last     = out_last;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_pop && !cmd.is_flush) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv && !(emit_full && (rem_after != '0))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sh_code_next   = sh_code;
    rem_next       = rem;
    partial_next   = partial;
    filled_next    = filled;
    out_valid_next = adv ? 1'b0 : out_valid;
    out_byte_next  = out_byte;
    out_last_next  = out_last;
    unique case (state)
      ST_IDLE: begin
        if (cmd_pop) begin
          if (cmd.is_flush) begin
            if (filled != '0) begin
              out_valid_next = 1'b1;
              out_byte_next  = partial;
              out_last_next  = 1'b1;
            end
            partial_next = '0;
            filled_next  = '0;
          end else begin
            sh_code_next = cmd.aligned;
            rem_next     = cmd.count;
          end
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (emit_full) begin
            out_valid_next = 1'b1;
            out_byte_next  = merged;
            out_last_next  = (rem_after < CNT_W'(BYTE_W));
            partial_next   = '0;
            filled_next    = '0;
            sh_code_next   = sh_code << need;
            rem_next       = rem_after;
          end else begin
            partial_next = merged;
            filled_next  = filled + rem[FILL_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      partial   <= '0;
      filled    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      partial   <= partial_next;
      filled    <= filled_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sh_code  <= sh_code_next;
    rem      <= rem_next;
    out_byte <= out_byte_next;
    out_last <= out_last_next;
  end

  `MFBP_ASSERT(a_run_has_bits, ((state == ST_RUN) |-> (rem != '0)), "engine runs with no bits left")
  `MFBP_ASSERT(a_partial_clean, ((partial & (8'hFF >> filled)) == '0), "stray bits below the fill mark")
  `MFBP_ASSERT(a_pop_when_idle, (cmd_pop |-> (state == ST_IDLE)), "command taken while busy")

endmodule
`default_nettype wire

// ===== rtl/msb_first_bit_packer.sv =====
// Top level of the MSB-first variable-length bit packer.
`default_nettype none
// The packer takes code words on the codes channel and delivers a byte stream on
// the bytes channel. An append word (func = 0) adds the low code_len bits of code,
// most significant bit first, to a partial byte that fills from bit 7 downward; a
// count above 64 is treated as 64 and a count of zero adds nothing. Every byte that
// fills is sent, and last marks the final byte produced by a word. A flush word
// (func = 1) sends the pending partial byte zero-padded at the bottom, if any bit is
// pending, with last set, and then clears it. The front end accepts one word per
// cycle into a two-entry command queue while that queue has room; zero-count
// appends are taken and dropped there. The packing engine behind the queue takes
// a command only while idle, then closes one output byte per step and finally
// merges any leftover bits into the partial byte before it turns idle again; a
// flush is handled as it is taken. The engine's single merge step, which closes at
// most one byte per cycle, sets the throughput; a registered output stage holds
// each finished byte, and the engine stalls while that byte waits to be taken.
module msb_first_bit_packer (
  input  logic        clk,
  input  logic        rst,
  mfbp_code_if.sink   codes,
  mfbp_byte_if.source bytes
);
  import mfbp_pkg::*;

  logic  push_valid;
  logic  push_ready;
  cmd_t  push_cmd;
  logic  pop_valid;
  logic  pop;
  cmd_t  pop_cmd;

  // Classification and alignment of incoming words.
  mfbp_front u_front (
    .codes      (codes),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // The queue lets the front end keep taking words while the engine emits bytes.
  mfbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  // The engine owns the partial byte and the output register.
  mfbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .cmd       (pop_cmd),
    .bytes     (bytes)
  );

endmodule
`default_nettype wire
